FILE: rtl/core/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// shared types, constants and reply byte lookup for the arp responder
// ----------------------------------------------------------------------------
package arpr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] FRAME_LEN = 6'd42;
  localparam logic [POS_W-1:0] LAST_IDX  = 6'd41;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] OP_REQUEST    = 16'h0001;
  localparam logic [15:0] OP_REPLY      = 16'h0002;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [15:0] HW_ETHERNET   = 16'h0001;
  localparam logic [7:0]  HW_LEN        = 8'd6;
  localparam logic [7:0]  PROTO_LEN     = 8'd4;

  localparam logic [IP_W-1:0]  OWN_IP_RESET  = 32'hC0A8_0701;
  localparam logic [MAC_W-1:0] OWN_MAC_RESET = 48'h0000_0000_0002;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b1;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } arpr_job_t;

  // octet k of a mac, first octet on the wire in the top bits
  function automatic logic [7:0] mac_octet(input logic [MAC_W-1:0] mac, input logic [2:0] k);
    logic [7:0] o;
    unique case (k)
      3'd0:    o = mac[47:40];
      3'd1:    o = mac[39:32];
      3'd2:    o = mac[31:24];
      3'd3:    o = mac[23:16];
      3'd4:    o = mac[15:8];
      default: o = mac[7:0];
    endcase
    return o;
  endfunction

  function automatic logic [7:0] ip_octet(input logic [IP_W-1:0] ip, input logic [1:0] k);
    logic [7:0] o;
    unique case (k)
      2'd0:    o = ip[31:24];
      2'd1:    o = ip[23:16];
      2'd2:    o = ip[15:8];
      default: o = ip[7:0];
    endcase
    return o;
  endfunction

  function automatic logic [7:0] reply_octet(input logic [POS_W-1:0] idx,
                                             input arpr_job_t job,
                                             input logic [MAC_W-1:0] own_mac,
                                             input logic [IP_W-1:0] own_ip);
    logic [POS_W-1:0] off6;
    logic [POS_W-1:0] off22;
    logic [POS_W-1:0] off28;
    logic [POS_W-1:0] off32;
    logic [POS_W-1:0] off38;
    logic [7:0]       o;
    off6  = idx - 6'd6;
    off22 = idx - 6'd22;
    off28 = idx - 6'd28;
    off32 = idx - 6'd32;
    off38 = idx - 6'd38;
    if (idx < 6'd6) begin
      o = mac_octet(job.mac, idx[2:0]);
    end else if (idx < 6'd12) begin
      o = mac_octet(own_mac, off6[2:0]);
    end else if (idx < 6'd22) begin
      unique case (idx)
        6'd12:   o = ETHERTYPE_ARP[15:8];
        6'd13:   o = ETHERTYPE_ARP[7:0];
        6'd14:   o = HW_ETHERNET[15:8];
        6'd15:   o = HW_ETHERNET[7:0];
        6'd16:   o = PROTO_IPV4[15:8];
        6'd17:   o = PROTO_IPV4[7:0];
        6'd18:   o = HW_LEN;
        6'd19:   o = PROTO_LEN;
        6'd20:   o = OP_REPLY[15:8];
        default: o = OP_REPLY[7:0];
      endcase
    end else if (idx < 6'd28) begin
      o = mac_octet(own_mac, off22[2:0]);
    end else if (idx < 6'd32) begin
      o = ip_octet(own_ip, off28[1:0]);
    end else if (idx < 6'd38) begin
      o = mac_octet(job.mac, off32[2:0]);
    end else begin
      o = ip_octet(job.ip, off38[1:0]);
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/arpr_parser.sv
// ----------------------------------------------------------------------------
// arpr_parser
// counts frame bytes, checks the ethertype, opcode and target ip fields and
// captures the requester addresses; queues a reply job when a matching frame ends
// ----------------------------------------------------------------------------
module arpr_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  input  logic [arpr_pkg::IP_W-1:0] own_ip_i,
  output logic                      push_o,
  output arpr_pkg::arpr_job_t       job_o
);
  import arpr_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             match_q, match_d;
  logic [MAC_W-1:0] mac_q, mac_d;
  logic [IP_W-1:0]  ip_q, ip_d;

  logic             in_range;
  logic             check_pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] tip_off;
  logic [7:0]       expect_byte;
  logic             mismatch;
  logic             match_next;

  assign in_range  = pos_q < FRAME_LEN;
  assign pos_next  = in_range ? pos_q + 6'd1 : pos_q;
  assign tip_off   = pos_q - 6'd38;
  assign check_pos = (pos_q == 6'd12) || (pos_q == 6'd13) || (pos_q == 6'd20) ||
                     (pos_q == 6'd21) || (pos_q >= 6'd38);

  always_comb begin
    priority if (pos_q == 6'd12) begin
      expect_byte = ETHERTYPE_ARP[15:8];
    end else if (pos_q == 6'd13) begin
      expect_byte = ETHERTYPE_ARP[7:0];
    end else if (pos_q == 6'd20) begin
      expect_byte = OP_REQUEST[15:8];
    end else if (pos_q == 6'd21) begin
      expect_byte = OP_REQUEST[7:0];
    end else begin
      expect_byte = ip_octet(own_ip_i, tip_off[1:0]);
    end
  end

  assign mismatch   = in_range && check_pos && (byte_i != expect_byte);
  assign match_next = match_q && !mismatch;
  assign push_o     = accept_i && last_i && match_next && (pos_next == FRAME_LEN);
  assign job_o      = '{mac: mac_q, ip: ip_q};

  always_comb begin
    pos_d   = pos_q;
    match_d = match_q;
    mac_d   = mac_q;
    ip_d    = ip_q;
    if (accept_i) begin
      if (in_range && pos_q >= 6'd6 && pos_q < 6'd12) begin
        mac_d = {mac_q[MAC_W-9:0], byte_i};
      end
      if (in_range && pos_q >= 6'd28 && pos_q < 6'd32) begin
        ip_d = {ip_q[IP_W-9:0], byte_i};
      end
      if (last_i) begin
        pos_d   = '0;
        match_d = 1'b1;
      end else begin
        pos_d   = pos_next;
        match_d = match_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 1'b1;
      mac_q   <= '0;
      ip_q    <= '0;
    end else begin
      pos_q   <= pos_d;
      match_q <= match_d;
      mac_q   <= mac_d;
      ip_q    <= ip_d;
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= FRAME_LEN)
    else $error("byte position past saturation");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> pos_q == '0 && match_q)
    else $error("frame end did not clear parser state");

endmodule

FILE: rtl/core/arpr_fifo.sv
// ----------------------------------------------------------------------------
// arpr_fifo
// small register queue of reply jobs between parser and reply generator
// ----------------------------------------------------------------------------
module arpr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == CntFull;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrMax) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrMax) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

FILE: rtl/core/arpr_gen.sv
// ----------------------------------------------------------------------------
// arpr_gen
// walks the head job of the queue and streams the 42-byte arp reply
// through an output register
// ----------------------------------------------------------------------------
module arpr_gen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  arpr_pkg::arpr_job_t        job_i,
  output logic                       pop_o,
  input  logic [arpr_pkg::MAC_W-1:0] own_mac_i,
  input  logic [arpr_pkg::IP_W-1:0]  own_ip_i,
  output logic                       tvalid_o,
  input  logic                       tready_i,
  output logic [7:0]                 tdata_o,
  output logic                       tlast_o
);
  import arpr_pkg::*;

  logic [POS_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;
  logic             adv;
  logic             at_end;

  assign adv    = job_valid_i && (!valid_q || tready_i);
  assign at_end = idx_q == LAST_IDX;
  assign pop_o  = adv && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    if (adv) begin
      data_d  = reply_octet(idx_q, job_i, own_mac_i, own_ip_i);
      last_d  = at_end;
      valid_d = 1'b1;
      idx_d   = at_end ? '0 : idx_q + 6'd1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = data_q;
  assign tlast_o  = last_q;

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q |-> idx_q == '0)
    else $error("reply end out of step with byte index");

endmodule

FILE: rtl/core/arp_request_responder_core.sv
// ----------------------------------------------------------------------------
// arp_request_responder_core
// answers arp requests for the configured own ip with a 42-byte reply
// ----------------------------------------------------------------------------
// input: one frame byte per cycle, tready drops only while the job queue is full
// the final frame byte transfer queues a job; its first reply byte then passes through the output register
// output: 42-byte replies, consecutive replies follow without a gap
// queue of QueueDepth reply jobs decouples parsing from reply streaming
// reset: own ip 192.168.7.1, own mac 2, queue and output empty, parser at byte 0
// ----------------------------------------------------------------------------
module arp_request_responder_core #(
  parameter int unsigned QueueDepth = arpr_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [arpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // frame_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // reply_byte
  output logic                            m_axis_tlast
);
  import arpr_pkg::*;

  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;

  logic             in_xfer;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  arpr_job_t        push_job;
  arpr_job_t        head_job;
  logic [$bits(arpr_job_t)-1:0] head_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= OWN_IP_RESET;
      own_mac_q <= OWN_MAC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OWN_IP:  own_ip_q  <= cfg_data_i[IP_W-1:0];
        REG_OWN_MAC: own_mac_q <= cfg_data_i[MAC_W-1:0];
        default:     ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  arpr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .own_ip_i (own_ip_q),
    .push_o   (push),
    .job_o    (push_job)
  );

  arpr_fifo #(
    .Width ($bits(arpr_job_t)),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_bits),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign head_job = arpr_job_t'(head_bits);

  arpr_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .own_mac_i   (own_mac_q),
    .own_ip_i    (own_ip_q),
    .tvalid_o    (m_axis_tvalid),
    .tready_i    (m_axis_tready),
    .tdata_o     (m_axis_tdata),
    .tlast_o     (m_axis_tlast)
  );

endmodule

FILE: sim/tb_arp_request_responder_core.sv
// ----------------------------------------------------------------------------
// tb_arp_request_responder_core
// streams ethernet frames into the arp responder and checks every reply byte
// against a cycle-free model of the parser and reply builder; covers valid
// requests, failed header and target checks, short and long frames, register
// settings, random traffic and a long output stall that backs up the input
// ----------------------------------------------------------------------------
module tb_arp_request_responder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import arpr_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_OWN_IP;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;  // frame_byte
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // reply_byte
  logic                  m_axis_tlast;

  // model state
  logic [IP_W-1:0]  own_ip_cfg  = OWN_IP_RESET;
  logic [MAC_W-1:0] own_mac_cfg = OWN_MAC_RESET;
  int               parse_pos   = 0;
  logic             parse_ok    = 1'b1;
  logic [MAC_W-1:0] peer_mac    = '0;
  logic [IP_W-1:0]  peer_ip     = '0;
  reply_beat_t      pending_reply[$];

  logic [7:0] tx_frame[$];
  int         mismatches   = 0;
  bit         tx_idle_en   = 1'b1;
  bit         rx_idle_en   = 1'b1;
  bit         hold_request = 1'b0;
  int         stall_left   = 0;

  arp_request_responder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [7:0] octet48(input logic [47:0] v, input int k);
    return v[47 - 8*k -: 8];
  endfunction

  function automatic logic [7:0] octet32(input logic [31:0] v, input int k);
    return v[31 - 8*k -: 8];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic logic [7:0] fill_byte(input int fill);
    if (fill < 0) return 8'($urandom);
    return 8'(fill);
  endfunction

  // expected 42-byte reply from captured peer and current registers
  task automatic push_reply();
    logic [7:0] b;
    for (int i = 0; i < 42; i++) begin
      if (i < 6) b = octet48(peer_mac, i);
      else if (i < 12) b = octet48(own_mac_cfg, i - 6);
      else if (i == 12) b = ETHERTYPE_ARP[15:8];
      else if (i == 13) b = ETHERTYPE_ARP[7:0];
      else if (i == 14) b = HW_ETHERNET[15:8];
      else if (i == 15) b = HW_ETHERNET[7:0];
      else if (i == 16) b = PROTO_IPV4[15:8];
      else if (i == 17) b = PROTO_IPV4[7:0];
      else if (i == 18) b = HW_LEN;
      else if (i == 19) b = PROTO_LEN;
      else if (i == 20) b = OP_REPLY[15:8];
      else if (i == 21) b = OP_REPLY[7:0];
      else if (i < 28) b = octet48(own_mac_cfg, i - 22);
      else if (i < 32) b = octet32(own_ip_cfg, i - 28);
      else if (i < 38) b = octet48(peer_mac, i - 32);
      else b = octet32(peer_ip, i - 38);
      pending_reply.push_back('{data: b, last: (i == 41)});
    end
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    logic [7:0] want;
    bit         checked;
    if (parse_pos < 42) begin
      if (parse_pos >= 6 && parse_pos < 12) peer_mac = {peer_mac[39:0], b};
      if (parse_pos >= 28 && parse_pos < 32) peer_ip = {peer_ip[23:0], b};
      checked = 1'b1;
      want    = '0;
      if (parse_pos == 12) want = ETHERTYPE_ARP[15:8];
      else if (parse_pos == 13) want = ETHERTYPE_ARP[7:0];
      else if (parse_pos == 20) want = OP_REQUEST[15:8];
      else if (parse_pos == 21) want = OP_REQUEST[7:0];
      else if (parse_pos >= 38) want = octet32(own_ip_cfg, parse_pos - 38);
      else checked = 1'b0;
      if (checked && b != want) parse_ok = 1'b0;
      parse_pos++;
    end
    if (last) begin
      if (parse_ok && parse_pos >= 42) push_reply();
      parse_pos = 0;
      parse_ok  = 1'b1;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_frame_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < tx_frame.size(); i++) begin
      send_byte(tx_frame[i], i == tx_frame.size() - 1);
    end
  endtask

  task automatic tx_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // arp request; fill < 0 puts random bytes in the unchecked filler fields
  task automatic build_request(input logic [47:0] mac, input logic [31:0] ip,
                               input logic [31:0] target, input int pad, input int fill);
    tx_frame.delete();
    for (int k = 0; k < 6; k++) tx_frame.push_back(fill_byte(fill));
    for (int k = 0; k < 6; k++) tx_frame.push_back(octet48(mac, k));
    tx_frame.push_back(ETHERTYPE_ARP[15:8]);
    tx_frame.push_back(ETHERTYPE_ARP[7:0]);
    tx_frame.push_back(HW_ETHERNET[15:8]);
    tx_frame.push_back(HW_ETHERNET[7:0]);
    tx_frame.push_back(PROTO_IPV4[15:8]);
    tx_frame.push_back(PROTO_IPV4[7:0]);
    tx_frame.push_back(HW_LEN);
    tx_frame.push_back(PROTO_LEN);
    tx_frame.push_back(OP_REQUEST[15:8]);
    tx_frame.push_back(OP_REQUEST[7:0]);
    for (int k = 0; k < 6; k++) tx_frame.push_back(octet48(mac, k));
    for (int k = 0; k < 4; k++) tx_frame.push_back(octet32(ip, k));
    for (int k = 0; k < 6; k++) tx_frame.push_back(fill_byte(fill));
    for (int k = 0; k < 4; k++) tx_frame.push_back(octet32(target, k));
    for (int k = 0; k < pad; k++) tx_frame.push_back(fill_byte(fill));
  endtask

  task automatic truncate_frame(input int len);
    logic [7:0] junk;
    while (tx_frame.size() > len) junk = tx_frame.pop_back();
  endtask

  task automatic corrupt_checked_byte();
    int r;
    int pos;
    r = $urandom_range(0, 7);
    if (r == 0) pos = 12;
    else if (r == 1) pos = 13;
    else if (r == 2) pos = 20;
    else if (r == 3) pos = 21;
    else pos = 38 + r - 4;
    tx_frame[pos] = tx_frame[pos] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic wait_idle();
    while (pending_reply.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_OWN_IP) own_ip_cfg = val[IP_W-1:0];
    else own_mac_cfg = val[MAC_W-1:0];
    @(posedge clk_i);
  endtask

  // reply side: random stalls, long hold-off on request, compare each transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reply.size() == 0) begin
        $display("%0t: unexpected reply transfer, expected none, got %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        reply_beat_t want;
        want = pending_reply.pop_front();
        if (m_axis_tdata !== want.data) begin
          $display("%0t: reply byte mismatch, expected %h, got %h",
                   $time, want.data, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: reply tlast mismatch, expected %b, got %b",
                   $time, want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      stall_left   = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic test_default_request();
    build_request(48'h0011_2233_4455, 32'h0A00_0001, OWN_IP_RESET, 0, -1);
    send_frame();
    tx_quiet();
  endtask

  task automatic test_byte_extremes();
    build_request(48'h0000_0000_0000, 32'h0000_0000, own_ip_cfg, 0, 8'h00);
    send_frame();
    tx_quiet();
  endtask

  task automatic test_failed_checks();
    // wrong ethertype, then wrong target ip
    build_request(48'h0200_0000_0001, 32'h0A00_0002, own_ip_cfg, 0, -1);
    tx_frame[13] = 8'h00;
    send_frame();
    build_request(48'h0200_0000_0003, 32'h0A00_0004, own_ip_cfg ^ 32'h1, 0, -1);
    send_frame();
    tx_quiet();
  endtask

  task automatic test_frame_lengths();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    // ends one byte short of a full request
    build_request(48'h0A0B_0C0D_0E0F, 32'hC0A8_0002, own_ip_cfg, 0, -1);
    truncate_frame(41);
    send_frame();
    build_request(48'h0A0B_0C0D_0E10, 32'hC0A8_0003, own_ip_cfg, 0, -1);
    truncate_frame(1);
    send_frame();
    tx_quiet();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_register_settings();
    wait_idle();
    write_reg(REG_OWN_IP, CFG_DATA_W'(32'hFFFF_FFFF));
    write_reg(REG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
    // long frame, trailing bytes ignored
    build_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, own_ip_cfg, 6, 8'hFF);
    send_frame();
    tx_quiet();
  endtask

  task automatic test_back_pressure();
    wait_idle();
    write_reg(REG_OWN_IP, CFG_DATA_W'($urandom));
    write_reg(REG_OWN_MAC, rand_mac());
    tx_idle_en = 1'b0;
    @(negedge clk_i);
    hold_request = 1'b1;
    @(posedge clk_i);
    for (int n = 0; n < 2; n++) begin
      build_request(rand_mac(), $urandom, own_ip_cfg, 0, -1);
      send_frame();
    end
    // queue is full here, this frame waits at its first byte
    tx_frame.delete();
    repeat (3) tx_frame.push_back(8'($urandom));
    send_frame();
    tx_quiet();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int counted;
    int r;
    wait_idle();
    write_reg(REG_OWN_IP, CFG_DATA_W'($urandom));
    write_reg(REG_OWN_MAC, rand_mac());
    counted = 0;
    while (counted < 40) begin
      r = $urandom_range(0, 99);
      build_request(rand_mac(), $urandom, own_ip_cfg,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6),
                    -1);
      if (r >= 55 && r < 70) begin
        corrupt_checked_byte();
      end else if (r >= 70 && r < 82) begin
        truncate_frame($urandom_range(1, 41));
      end else if (r >= 82) begin
        tx_frame.delete();
        repeat ($urandom_range(1, 64)) tx_frame.push_back(8'($urandom));
      end
      counted += tx_frame.size();
      send_frame();
    end
    tx_quiet();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_request();
    test_byte_extremes();
    test_failed_checks();
    test_frame_lengths();
    test_register_settings();
    test_back_pressure();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_reply.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d reply bytes outstanding", $time, pending_reply.size());
    $display("Verification failed");
    $finish;
  end

endmodule
